/* rtl/hlb_pkg.sv */
// ----------------------------------------------------------------------------
// hlb_pkg
// Shared types, constants and elaboration helpers for the hierarchical
// latching bitset: level geometry, reset word pattern, lowest-zero search.
// ----------------------------------------------------------------------------
`default_nettype none

package hlb_pkg;

  localparam int WORD_BITS    = 64;
  localparam int LEVEL_MAX    = 6;
  localparam int DEF_MAX_BITS = 4096;
  localparam int CNT_W        = 13;
  localparam int IDX_W        = 12;
  localparam int CNT_RESET    = 4096;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] first_free;
    logic             full_res;
    logic             index_error;
  } hlb_res_t;

  // Words in level l for a store of max_bits positions.
  function automatic int lvl_words(input int max_bits, input int l);
    int size;
    int words;
    int r;
    size = max_bits;
    r    = 0;
    for (int i = 0; i < LEVEL_MAX; i++) begin
      words = (size + 63) >> 6;
      if (i == l) r = words;
      size = words;
    end
    return r;
  endfunction

  // Level count: stop once a level fits in one word.
  function automatic int lvl_count(input int max_bits);
    int  n;
    logic stop;
    n    = 0;
    stop = 1'b0;
    for (int i = 0; i < LEVEL_MAX; i++) begin
      if (!stop) begin
        n = n + 1;
        if (lvl_words(max_bits, i) <= 1) stop = 1'b1;
      end
    end
    return n;
  endfunction

  // First word of level l; level 0 starts at address zero.
  function automatic int lvl_start(input int max_bits, input int l);
    int s;
    s = 0;
    for (int i = 0; i < LEVEL_MAX; i++) begin
      if (i < l) s = s + lvl_words(max_bits, i);
    end
    return s;
  endfunction

  function automatic int total_words(input int max_bits);
    return lvl_start(max_bits, lvl_count(max_bits));
  endfunction

  function automatic int addr_width(input int max_bits);
    int t;
    t = total_words(max_bits);
    return (t > 1) ? $clog2(t) : 1;
  endfunction

  // Reset pattern of word w of a level: bit b is one exactly when
  // w*64+b reaches the count of that level, ceil(cnt / 64^level).
  function automatic logic [WORD_BITS-1:0] init_word(input int level, input int w,
                                                     input logic [CNT_W-1:0] cnt);
    int sh;
    int c;
    int base;
    logic [WORD_BITS-1:0] v;
    sh   = 6 * level;
    c    = (int'(cnt) + (1 << sh) - 1) >> sh;
    base = w << 6;
    if (base + WORD_BITS <= c) begin
      v = '0;
    end else if (base >= c) begin
      v = '1;
    end else begin
      v = ~((64'd1 << (c - base)) - 64'd1);
    end
    return v;
  endfunction

  // Lowest clear bit; bit 6 of the result flags a word of all ones.
  function automatic logic [6:0] first_zero(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] m;
    logic [6:0]           r;
    m = ~v & (v + 64'd1);
    r = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (m[b]) r[5:0] = r[5:0] | 6'(b);
    end
    r[6] = (m == '0);
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/hlb_ram.sv */
// ----------------------------------------------------------------------------
// hlb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hlb_ram #(
  parameter int WIDTH  = hlb_pkg::WORD_BITS,
  parameter int DEPTH  = 65,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/hlb_init.sv */
// ----------------------------------------------------------------------------
// hlb_init
// Clearing pass: sweeps every word of the store once after reset or a count
// write and writes its preset pattern (padding and full summary bits set).
// ----------------------------------------------------------------------------
`default_nettype none

module hlb_init #(
  parameter int MAX_BITS = hlb_pkg::DEF_MAX_BITS,
  parameter int ADDR_W   = hlb_pkg::addr_width(MAX_BITS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [hlb_pkg::CNT_W-1:0]     cnt,
  output logic                          active,
  output logic [ADDR_W-1:0]             wr_addr,
  output logic [hlb_pkg::WORD_BITS-1:0] wr_data
);

  import hlb_pkg::*;

  localparam int LEVELS = lvl_count(MAX_BITS);
  localparam int TOTAL  = total_words(MAX_BITS);

  logic [ADDR_W-1:0] addr;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      active <= 1'b1;
      addr   <= '0;
    end else if (active) begin
      if (addr == ADDR_W'(TOTAL - 1)) active <= 1'b0;
      addr <= addr + ADDR_W'(1);
    end
  end

  always_comb begin
    int lvl_sel;
    int w_sel;
    lvl_sel = 0;
    w_sel   = 0;
    for (int l = 0; l < LEVEL_MAX; l++) begin
      if (l < LEVELS && int'(addr) >= lvl_start(MAX_BITS, l)) begin
        lvl_sel = l;
        w_sel   = int'(addr) - lvl_start(MAX_BITS, l);
      end
    end
    wr_data = init_word(lvl_sel, w_sel, cnt);
  end

  assign wr_addr = addr;

endmodule

`default_nettype wire

/* rtl/hlb_walk.sv */
// ----------------------------------------------------------------------------
// hlb_walk
// Item sequencer: read-modify-write of one word per level on the way up,
// then a descent from the cached top word to the lowest clear position.
// Forwards the last written word to a read of the same address.
// ----------------------------------------------------------------------------
`default_nettype none

module hlb_walk #(
  parameter int MAX_BITS = hlb_pkg::DEF_MAX_BITS,
  parameter int ADDR_W   = hlb_pkg::addr_width(MAX_BITS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic                          operation,
  input  logic [hlb_pkg::IDX_W-1:0]     index,
  input  logic [hlb_pkg::CNT_W-1:0]     cnt,
  input  logic [hlb_pkg::WORD_BITS-1:0] top_word,
  output logic [ADDR_W-1:0]             rd_addr,
  input  logic [hlb_pkg::WORD_BITS-1:0] rd_data,
  output logic                          wr_en,
  output logic [ADDR_W-1:0]             wr_addr,
  output logic [hlb_pkg::WORD_BITS-1:0] wr_data,
  output logic                          busy,
  output logic                          done,
  output hlb_pkg::hlb_res_t             res
);

  import hlb_pkg::*;

  localparam int LEVELS   = lvl_count(MAX_BITS);
  localparam int TOP_ADDR = lvl_start(MAX_BITS, LEVELS - 1);
  localparam int L0_WORDS = lvl_words(MAX_BITS, 0);
  localparam int POS_W    = $clog2(MAX_BITS);
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DN_LVL   = (LEVELS > 1) ? LEVELS - 2 : 0;

  typedef enum logic [1:0] {S_IDLE, S_UP, S_DN} state_t;

  state_t                 state, state_next;
  logic                   op_q, op_next;
  logic                   err_q, err_next;
  logic                   hit_q, hit_next;
  logic [LVL_W-1:0]       lvl, lvl_next;
  logic [POS_W-1:0]       pos, pos_next;
  logic [ADDR_W-1:0]      raddr_q;
  logic                   fwd_hit;
  logic [WORD_BITS-1:0]   fwd_data;

  logic [WORD_BITS-1:0]   word;
  logic [WORD_BITS-1:0]   modified;
  logic [WORD_BITS-1:0]   top_cur;
  logic [WORD_BITS-1:0]   fz_src;
  logic [6:0]             fz;
  logic [5:0]             bsel;
  logic [5:0]             idx_word;
  logic [POS_W+5:0]       pos_cat;
  logic [POS_W-1:0]       newpos;
  logic                   is_set, do_wr, climb, hit_now, hit_out, full_now;
  logic                   fin;
  hlb_res_t               fin_res;

  function automatic logic [ADDR_W-1:0] start_of(input int l);
    logic [ADDR_W-1:0] s;
    s = '0;
    for (int k = 0; k < LEVEL_MAX; k++) begin
      if (k == l) s = ADDR_W'(lvl_start(MAX_BITS, k));
    end
    return s;
  endfunction

  function automatic logic [CNT_W-1:0] clip(input logic [POS_W-1:0] p,
                                            input logic [CNT_W-1:0] c);
    return (32'(p) < 32'(c)) ? CNT_W'(p) : c;
  endfunction

  // Read data of a word written in the cycle its read was issued comes from
  // the forward register; the RAM returns the old contents then.
  assign word     = fwd_hit ? fwd_data : rd_data;
  assign bsel     = pos[5:0];
  assign is_set   = word[bsel];
  assign modified = word | (64'd1 << bsel);
  assign do_wr    = !err_q && !op_q && !(lvl == '0 && is_set);
  assign climb    = do_wr && (modified == '1) && (int'(lvl) < LEVELS - 1);
  assign hit_now  = !err_q && (op_q ? is_set : !is_set);
  assign hit_out  = (lvl == '0) ? hit_now : hit_q;
  assign top_cur  = (do_wr && raddr_q == ADDR_W'(TOP_ADDR)) ? modified : top_word;
  assign full_now = (cnt == '0) || (top_cur == '1);
  assign fz_src   = (state == S_UP) ? top_cur : word;
  assign fz       = first_zero(fz_src);
  assign pos_cat  = {pos, fz[5:0]};
  assign newpos   = pos_cat[POS_W-1:0];
  assign idx_word = index[IDX_W-1:6];

  assign wr_addr  = raddr_q;
  assign wr_data  = modified;
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op_q;
    err_next   = err_q;
    hit_next   = hit_q;
    lvl_next   = lvl;
    pos_next   = pos;
    rd_addr    = '0;
    wr_en      = 1'b0;
    fin        = 1'b0;
    fin_res    = '0;
    case (state)
      S_IDLE: begin
        if (go) begin
          op_next    = operation;
          err_next   = ({1'b0, index} >= cnt);
          hit_next   = 1'b0;
          lvl_next   = '0;
          pos_next   = POS_W'(index);
          rd_addr    = (32'(idx_word) < 32'(L0_WORDS)) ? ADDR_W'(idx_word) : '0;
          state_next = S_UP;
        end
      end
      S_UP: begin
        wr_en = do_wr;
        if (lvl == '0) hit_next = hit_now;
        fin_res.hit         = hit_out;
        fin_res.index_error = err_q;
        if (climb) begin
          // Word just became full: set its bit one level up.
          lvl_next = lvl + LVL_W'(1);
          pos_next = pos >> 6;
          rd_addr  = start_of(int'(lvl) + 1) + ADDR_W'(pos >> 12);
        end else if (full_now) begin
          fin                 = 1'b1;
          fin_res.full_res    = 1'b1;
          fin_res.first_free  = cnt;
        end else if (LEVELS == 1) begin
          fin                 = 1'b1;
          fin_res.first_free  = clip(POS_W'(fz[5:0]), cnt);
        end else begin
          lvl_next   = LVL_W'(DN_LVL);
          pos_next   = POS_W'(fz[5:0]);
          rd_addr    = start_of(DN_LVL) + ADDR_W'(fz[5:0]);
          state_next = S_DN;
        end
      end
      S_DN: begin
        fin_res.hit         = hit_q;
        fin_res.index_error = err_q;
        if (fz[6]) begin
          fin                = 1'b1;
          fin_res.first_free = cnt;
        end else if (lvl == '0) begin
          fin                = 1'b1;
          fin_res.first_free = clip(newpos, cnt);
        end else begin
          lvl_next = lvl - LVL_W'(1);
          pos_next = newpos;
          rd_addr  = start_of(int'(lvl) - 1) + ADDR_W'(newpos);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) state_next = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      state   <= state_next;
      done    <= fin;
      fwd_hit <= wr_en && (wr_addr == rd_addr);
      if (fin) res <= fin_res;
    end
    op_q     <= op_next;
    err_q    <= err_next;
    hit_q    <= hit_next;
    lvl      <= lvl_next;
    pos      <= pos_next;
    raddr_q  <= rd_addr;
    fwd_data <= wr_data;
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_en)
    else $error("store written while idle");

  a_err_no_hit: assert property (@(posedge clk) disable iff (rst)
    (done && res.index_error) |-> !res.hit)
    else $error("hit reported on an out-of-range item");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && res.full_res) |-> (res.first_free == cnt))
    else $error("full store reports a clear position below the count");

  a_fm_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.first_free <= cnt))
    else $error("first_free beyond the count");

  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    go |-> (state == S_IDLE))
    else $error("item taken while a walk is in progress");

endmodule

`default_nettype wire

/* rtl/hierarchical_latching_bitset_core.sv */
// ----------------------------------------------------------------------------
// hierarchical_latching_bitset_core
// Set-only bitset with 64-bit summary levels and lowest-clear-position search.
// An item's walk climbs the levels it touches (1 to LEVELS) going up, then
//   makes LEVELS-1 descent reads (none when full) to the lowest clear position.
//   busy falls as done rises, so the next item can be taken while done is
//   high; each item's walk ends before the next one is accepted.
// Reset or a count write runs a clearing pass of one word per cycle over
//   all store words with busy high.
// Results cannot be stalled; each is shown for one cycle with done.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_latching_bitset_core #(
  parameter int MAX_BITS = hlb_pkg::DEF_MAX_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      operation,
  input  logic [hlb_pkg::IDX_W-1:0] index,
  output logic                      done,
  output logic                      hit,
  output logic [hlb_pkg::CNT_W-1:0] first_free,
  output logic                      full_res,
  output logic                      index_error,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hlb_pkg::CNT_W-1:0] cfg_data
);

  import hlb_pkg::*;

  localparam int TOTAL    = total_words(MAX_BITS);
  localparam int ADDR_W   = addr_width(MAX_BITS);
  localparam int TOP_ADDR = lvl_start(MAX_BITS, lvl_count(MAX_BITS) - 1);
  localparam int CNT_INIT = (CNT_RESET > MAX_BITS) ? MAX_BITS : CNT_RESET;

  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cfg_eff;
  logic                 cfg_wr;
  logic [WORD_BITS-1:0] top_word;
  logic                 go;

  logic                 init_active;
  logic [ADDR_W-1:0]    init_addr;
  logic [WORD_BITS-1:0] init_data;

  logic                 walk_busy;
  logic [ADDR_W-1:0]    walk_raddr;
  logic                 walk_we;
  logic [ADDR_W-1:0]    walk_waddr;
  logic [WORD_BITS-1:0] walk_wdata;
  hlb_res_t             walk_res;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  // Counts above the store size work as the store size.
  assign cfg_eff   = (32'(cfg_data) > 32'(MAX_BITS)) ? CNT_W'(MAX_BITS) : cfg_data;

  assign busy = init_active | walk_busy;
  assign go   = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CNT_W'(CNT_INIT);
    end else if (cfg_wr) begin
      cnt <= cfg_eff;
    end
    // Mirror the top word so the descent starts without a RAM read.
    if (ram_we && ram_waddr == ADDR_W'(TOP_ADDR)) begin
      top_word <= ram_wdata;
    end
  end

  assign ram_we    = init_active | walk_we;
  assign ram_waddr = init_active ? init_addr : walk_waddr;
  assign ram_wdata = init_active ? init_data : walk_wdata;

  hlb_init #(
    .MAX_BITS (MAX_BITS),
    .ADDR_W   (ADDR_W)
  ) u_init (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr),
    .cnt     (cnt),
    .active  (init_active),
    .wr_addr (init_addr),
    .wr_data (init_data)
  );

  hlb_walk #(
    .MAX_BITS (MAX_BITS),
    .ADDR_W   (ADDR_W)
  ) u_walk (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .operation (operation),
    .index     (index),
    .cnt       (cnt),
    .top_word  (top_word),
    .rd_addr   (walk_raddr),
    .rd_data   (ram_rdata),
    .wr_en     (walk_we),
    .wr_addr   (walk_waddr),
    .wr_data   (walk_wdata),
    .busy      (walk_busy),
    .done      (done),
    .res       (walk_res)
  );

  hlb_ram #(
    .WIDTH  (WORD_BITS),
    .DEPTH  (TOTAL),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (walk_raddr),
    .rdata (ram_rdata)
  );

  assign hit         = walk_res.hit;
  assign first_free  = walk_res.first_free;
  assign full_res    = walk_res.full_res;
  assign index_error = walk_res.index_error;

endmodule

`default_nettype wire

/* verif/hlb_bitset_tb_pkg.sv */
// ----------------------------------------------------------------------------
// hlb_bitset_tb_pkg
// Operation codes shared by the bitset testbench top and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package hlb_bitset_tb_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TEST   = 1'b1
  } bitset_op_e;

endpackage

/* verif/hlb_bitset_checker.sv */
// ----------------------------------------------------------------------------
// hlb_bitset_checker
// Watches the item, result and count channels of the bitset core, keeps
// its own two-level copy of the store, predicts every result when its item
// is accepted and compares each strobed result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hlb_bitset_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      operation,
  input  logic [hlb_pkg::IDX_W-1:0] index,
  input  logic                      done,
  input  logic                      hit,
  input  logic [hlb_pkg::CNT_W-1:0] first_free,
  input  logic                      full_res,
  input  logic                      index_error,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [hlb_pkg::CNT_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        answers_owed,
  output int                        items_seen,
  output int                        fulls_seen,
  output int                        errors_seen
);

  import hlb_pkg::*;
  import hlb_bitset_tb_pkg::*;

  localparam int LEAF_WORDS = DEF_MAX_BITS / WORD_BITS;

  logic [WORD_BITS-1:0] leaf_words [LEAF_WORDS];
  logic [WORD_BITS-1:0] summary_word;
  logic [CNT_W-1:0]     count_reg;
  hlb_res_t             answer_q [$];

  // Counts above the store size saturate.
  function automatic int usable_bits();
    return (int'(count_reg) > DEF_MAX_BITS) ? DEF_MAX_BITS : int'(count_reg);
  endfunction

  function automatic int lowest_zero(input logic [WORD_BITS-1:0] v);
    for (int b = 0; b < WORD_BITS; b++) begin
      if (!v[b]) return b;
    end
    return WORD_BITS;
  endfunction

  task automatic rebuild_store(input logic [CNT_W-1:0] value);
    int cnt;
    int base;
    count_reg    = value;
    cnt          = usable_bits();
    summary_word = '0;
    for (int w = 0; w < LEAF_WORDS; w++) begin
      base = w * WORD_BITS;
      // preset padding past the count to one
      if (base + WORD_BITS <= cnt) begin
        leaf_words[w] = '0;
      end else if (base >= cnt) begin
        leaf_words[w] = '1;
      end else begin
        leaf_words[w] = ~((64'd1 << (cnt - base)) - 64'd1);
      end
      summary_word[w] = &leaf_words[w];
    end
  endtask

  function automatic logic store_full();
    return (usable_bits() == 0) || (&summary_word);
  endfunction

  // Descend from the summary word to the first leaf word with a hole.
  function automatic int first_clear();
    int cnt;
    int top_bit;
    int pos;
    cnt = usable_bits();
    if (store_full()) return cnt;
    top_bit = lowest_zero(summary_word);
    pos     = top_bit * WORD_BITS + lowest_zero(leaf_words[top_bit]);
    return (pos < cnt) ? pos : cnt;
  endfunction

  function automatic hlb_res_t apply_item(input logic op, input logic [IDX_W-1:0] idx);
    hlb_res_t r;
    int       w;
    int       b;
    r = '0;
    w = int'(idx) / WORD_BITS;
    b = int'(idx) % WORD_BITS;
    if (int'(idx) >= usable_bits()) begin
      r.index_error = 1'b1;
    end else if (op == OP_INSERT) begin
      if (!leaf_words[w][b]) begin
        leaf_words[w][b] = 1'b1;
        r.hit            = 1'b1;
        // latch the summary bit once the leaf word fills
        if (&leaf_words[w]) summary_word[w] = 1'b1;
      end
    end else begin
      r.hit = leaf_words[w][b];
    end
    r.first_free = CNT_W'(first_clear());
    r.full_res   = store_full();
    return r;
  endfunction

  always @(posedge clk) begin
    hlb_res_t want;
    if (rst) begin
      rebuild_store(CNT_W'(CNT_RESET));
      answer_q.delete();
    end else begin
      if (done) begin
        if (answer_q.size() == 0) begin
          $error("result strobed with no item outstanding");
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, hit);
            fail_count++;
          end
          if (first_free !== want.first_free) begin
            $error("first_free: expected %0d, actual %0d",
                   want.first_free, first_free);
            fail_count++;
          end
          if (full_res !== want.full_res) begin
            $error("full_res: expected %0d, actual %0d", want.full_res, full_res);
            fail_count++;
          end
          if (index_error !== want.index_error) begin
            $error("index_error: expected %0d, actual %0d",
                   want.index_error, index_error);
            fail_count++;
          end
          if (want.full_res) fulls_seen++;
          if (want.index_error) errors_seen++;
        end
      end
      if (cfg_valid && cfg_ready) rebuild_store(cfg_data);
      if (start && !busy) begin
        answer_q.push_back(apply_item(operation, index));
        items_seen++;
      end
    end
    answers_owed = answer_q.size();
  end

endmodule

/* verif/tb_hierarchical_latching_bitset_core.sv */
// ----------------------------------------------------------------------------
// tb_hierarchical_latching_bitset_core
// Drives directed and random insert/test items into the bitset core across
// many count settings, with random start gaps; a checker beside the core
// predicts and compares every result and reports its failure count here.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hierarchical_latching_bitset_core;
  import hlb_pkg::*;
  import hlb_bitset_tb_pkg::*;

  localparam int    ITEM_TARGET  = 1050;
  localparam int    QUIET_LO     = 500;
  localparam int    QUIET_HI     = 700;
  localparam int    DRAIN_CYCLES = 20;
  localparam int    CNT_MAX      = (1 << CNT_W) - 1;
  localparam longint RUN_LIMIT_NS = 64'd4_000_000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             operation;
  logic [IDX_W-1:0] index;
  logic             done;
  logic             hit;
  logic [CNT_W-1:0] first_free;
  logic             full_res;
  logic             index_error;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  int fail_count;
  int answers_owed;
  int items_seen;
  int fulls_seen;
  int errors_seen;
  int sent_cnt;
  int cfg_writes;
  int live_count;

  hierarchical_latching_bitset_core i_dut (.*);

  hlb_bitset_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL hierarchical_latching_bitset_core");
    $finish;
  end

  task automatic send_item(input bitset_op_e op, input int idx);
    if (!(sent_cnt >= QUIET_LO && sent_cnt < QUIET_HI) && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    index     <= idx[IDX_W-1:0];
    do @(posedge clk); while (busy);
    sent_cnt++;
  endtask

  // Write only once every result has come back.
  task automatic write_count(input int value);
    start <= 1'b0;
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
    if ($urandom_range(0, 99) < 14) repeat ($urandom_range(1, 6)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[CNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cfg_writes++;
    live_count = (value > DEF_MAX_BITS) ? DEF_MAX_BITS : value;
  endtask

  function automatic int pick_count();
    int c;
    case ($urandom_range(0, 9))
      0:       c = 0;
      1:       c = DEF_MAX_BITS;
      2:       c = $urandom_range(DEF_MAX_BITS + 1, CNT_MAX);
      3:       c = $urandom_range(1, 64);
      4:       c = $urandom_range(65, 200);
      5:       c = 64 * $urandom_range(1, 64);
      6:       c = 64 * $urandom_range(1, 63) + 1;
      7:       c = 64 * $urandom_range(1, 64) - 1;
      default: c = $urandom_range(1, DEF_MAX_BITS);
    endcase
    return c;
  endfunction

  function automatic int noise_index();
    int idx;
    if ($urandom_range(0, 1) || live_count == 0) begin
      idx = $urandom_range(0, (1 << IDX_W) - 1);
    end else begin
      // hover around the top of the valid range
      idx = live_count - 1 + $urandom_range(0, 2);
    end
    return (idx > (1 << IDX_W) - 1) ? (1 << IDX_W) - 1 : idx;
  endfunction

  // Fill one or two leaf words in shuffled order, mixed with tests and noise.
  task automatic run_fill_phase();
    int words;
    int span;
    int lo;
    int hi;
    int k;
    int tmp;
    int r;
    int order [$];
    write_count(pick_count());
    if (live_count == 0) begin
      repeat (20) send_item(bitset_op_e'($urandom_range(0, 1)), noise_index());
      return;
    end
    words = (live_count + WORD_BITS - 1) / WORD_BITS;
    span  = $urandom_range(1, 2);
    if (span > words) span = words;
    lo = WORD_BITS * $urandom_range(0, words - span);
    hi = lo + span * WORD_BITS;
    if (hi > live_count) hi = live_count;
    for (int p = lo; p < hi; p++) order.push_back(p);
    for (int j = order.size() - 1; j > 0; j--) begin
      k        = $urandom_range(0, j);
      tmp      = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    while (order.size() > 0 && sent_cnt < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_item(OP_INSERT, order.pop_front());
      end else if (r < 85) begin
        send_item(OP_TEST, lo + $urandom_range(0, hi - lo - 1));
      end else if (r < 92) begin
        send_item(OP_INSERT, lo + $urandom_range(0, hi - lo - 1));
      end else begin
        send_item(bitset_op_e'($urandom_range(0, 1)), noise_index());
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    operation  = OP_INSERT;
    index      = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    sent_cnt   = 0;
    cfg_writes = 0;
    live_count = CNT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset count: set, repeat and test at both ends
    send_item(OP_TEST, 0);
    send_item(OP_INSERT, 0);
    send_item(OP_INSERT, 0);
    send_item(OP_TEST, 0);
    send_item(OP_INSERT, 4095);
    send_item(OP_TEST, 4095);
    send_item(OP_TEST, 2048);
    // empty store: every index is out of range
    write_count(0);
    send_item(OP_INSERT, 0);
    send_item(OP_TEST, 4095);
    // single position fills the store
    write_count(1);
    send_item(OP_TEST, 0);
    send_item(OP_INSERT, 1);
    send_item(OP_INSERT, 0);
    // one valid bit in the second word: filling it sets its summary bit
    write_count(65);
    send_item(OP_INSERT, 64);
    send_item(OP_TEST, 64);
    send_item(OP_INSERT, 63);
    // count above the store size saturates
    write_count(CNT_MAX);
    send_item(OP_INSERT, 4095);
    send_item(OP_TEST, 4095);
    send_item(OP_INSERT, 4094);
    send_item(OP_TEST, 0);
    write_count(DEF_MAX_BITS);
    send_item(OP_INSERT, 12'hAAA);
    send_item(OP_INSERT, 12'h555);
    send_item(OP_TEST, 12'hAAA);
    write_count(DEF_MAX_BITS - 1);
    send_item(OP_INSERT, 4095);
    send_item(OP_INSERT, 4094);

    while (sent_cnt < ITEM_TARGET) run_fill_phase();

    start <= 1'b0;
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d items over %0d count writes", items_seen, cfg_writes);
    $display("Results with store full: %0d, with index error: %0d", fulls_seen, errors_seen);
    if (fail_count == 0) begin
      $display("PASS hierarchical_latching_bitset_core");
    end else begin
      $display("FAIL hierarchical_latching_bitset_core");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hlb_pkg.sv
rtl/hlb_ram.sv
rtl/hlb_init.sv
rtl/hlb_walk.sv
rtl/hierarchical_latching_bitset_core.sv
verif/hlb_bitset_tb_pkg.sv
verif/hlb_bitset_checker.sv
verif/tb_hierarchical_latching_bitset_core.sv
